/* rtl/assert_macros.svh */
// Assertion macros shared by the checking code of the cipher block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property check failed");
// Checks that a state vector holds exactly one hot bit.
`define ASSERT_ONEHOT(lbl, clk, rst_n, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) $onehot(sig)) \
        else $error("one-hot check failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_ONEHOT(lbl, clk, rst_n, sig)
`endif
`endif

/* rtl/pr80_pkg.sv */
// Package with types, tables and round functions of the PRESENT-80 cipher block.
`timescale 1ns / 1ps
package pr80_pkg;

    // Largest round count that the engine runs.
    localparam int MAX_ROUNDS = 31;
    // Default depth of the request queue between front and engine.
    localparam int QUEUE_DEPTH = 2;

    // Register byte addresses on the configuration port.
    typedef enum logic [4:0] {
        ADDR_ROUND_COUNT = 5'd0,
        ADDR_KEY_UPPER   = 5'd8,
        ADDR_KEY_LOWER   = 5'd16
    } t_reg_addr;

    // Cipher direction of one request.
    typedef enum logic {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } t_mode;

    // One classified request as it waits in the queue.
    typedef struct packed {
        t_mode       mode;
        logic        tap_both;
        logic [4:0]  rounds;
        logic [63:0] text;
    } t_req;

    // One result as it leaves the engine.
    typedef struct packed {
        logic [4:0]  round_index;
        logic [63:0] tap_first;
        logic [63:0] tap_second;
        logic [63:0] text_out;
        logic        last;
    } t_res;

    // The 80-bit key register, split as the configuration holds it.
    typedef struct packed {
        logic [63:0] hi;
        logic [15:0] lo;
    } t_key;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    localparam logic [3:0] SBOX_INV [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    // S-box layer over all sixteen nibbles.
    function automatic logic [63:0] sub_fwd(input logic [63:0] s);
        logic [63:0] t;
        t = '0;
        for (int i = 0; i < 16; i++) begin
            t[4*i +: 4] = SBOX[s[4*i +: 4]];
        end
        return t;
    endfunction

    function automatic logic [63:0] sub_inv(input logic [63:0] s);
        logic [63:0] t;
        t = '0;
        for (int i = 0; i < 16; i++) begin
            t[4*i +: 4] = SBOX_INV[s[4*i +: 4]];
        end
        return t;
    endfunction

    // Bit permutation: bit k moves to 16*(k mod 4) + k/4.
    function automatic logic [63:0] perm_fwd(input logic [63:0] s);
        logic [63:0] t;
        logic [5:0]  kb;
        t = '0;
        for (int k = 0; k < 64; k++) begin
            kb = 6'(k);
            t[{kb[1:0], kb[5:2]}] = s[k];
        end
        return t;
    endfunction

    // Inverse permutation: bit k moves to 4*(k mod 16) + k/16.
    function automatic logic [63:0] perm_inv(input logic [63:0] s);
        logic [63:0] t;
        logic [5:0]  kb;
        t = '0;
        for (int k = 0; k < 64; k++) begin
            kb = 6'(k);
            t[{kb[3:0], kb[5:4]}] = s[k];
        end
        return t;
    endfunction

    // One step of the key schedule: rotate left by 61, S-box on the top
    // nibble, round counter into key bits 19 to 15.
    function automatic t_key key_fwd(input t_key k, input logic [4:0] ctr);
        logic [79:0] f;
        f = {k.hi, k.lo};
        f = {f[18:0], f[79:19]};
        f[79:76] = SBOX[f[79:76]];
        f[19:15] = f[19:15] ^ ctr;
        return t_key'(f);
    endfunction

    // Undoes one step of the key schedule taken with the given counter.
    function automatic t_key key_inv(input t_key k, input logic [4:0] ctr);
        logic [79:0] f;
        f = {k.hi, k.lo};
        f[19:15] = f[19:15] ^ ctr;
        f[79:76] = SBOX_INV[f[79:76]];
        f = {f[60:0], f[79:61]};
        return t_key'(f);
    endfunction

endpackage

/* rtl/pr80_in_if.sv */
// Input channel of the cipher block: one block request per handshake.
`timescale 1ns / 1ps
interface pr80_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic        tap_both;
    logic [63:0] text_in;

    modport source (output valid, output mode, output tap_both, output text_in,
                    input ready);
    modport sink (input valid, input mode, input tap_both, input text_in,
                  output ready);
endinterface

/* rtl/pr80_out_if.sv */
// Output channel of the cipher block: one tap or final result per handshake.
`timescale 1ns / 1ps
interface pr80_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  round_index;
    logic [63:0] tap_first;
    logic [63:0] tap_second;
    logic [63:0] text_out;
    logic        last;

    modport source (output valid, output round_index, output tap_first,
                    output tap_second, output text_out, output last, input ready);
    modport sink (input valid, input round_index, input tap_first,
                  input tap_second, input text_out, input last, output ready);
endinterface

/* rtl/pr80_front.sv */
// Front end: accepts block requests and classifies them for the queue.
`timescale 1ns / 1ps
module pr80_front (
    pr80_in_if.sink        i_in,
    input  logic [4:0]     i_round_count,
    input  logic           i_full,
    output logic           o_push,
    output pr80_pkg::t_req o_req
);

    logic [4:0] rounds_sat;

    // Saturate the configured round count to the supported maximum.
    always_comb begin
        if (i_round_count > 5'(pr80_pkg::MAX_ROUNDS)) begin
            rounds_sat = 5'(pr80_pkg::MAX_ROUNDS);
        end else begin
            rounds_sat = i_round_count;
        end
    end

    // A request is taken whenever the queue has room.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Pack the request with its effective round count.
    always_comb begin
        o_req.mode     = pr80_pkg::t_mode'(i_in.mode);
        o_req.tap_both = i_in.tap_both;
        o_req.rounds   = rounds_sat;
        o_req.text     = i_in.text_in;
    end

endmodule

/* rtl/pr80_queue.sv */
// Short request queue that decouples the front end from the round engine.
`timescale 1ns / 1ps
module pr80_queue #(
    parameter int DEPTH = pr80_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pr80_pkg::t_req i_req,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output pr80_pkg::t_req o_req
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    pr80_pkg::t_req r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count updates.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

endmodule

/* rtl/pr80_engine.sv */
// Round engine: runs the key schedule and one cipher round per cycle while not stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pr80_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  pr80_pkg::t_req i_q_req,
    output logic           o_q_pop,
    input  logic [63:0]    i_key_upper,
    input  logic [15:0]    i_key_lower,
    input  logic           i_cfg_wr,
    pr80_out_if.source     o_out
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WARM = 3'b010,
        ST_RUN  = 3'b100
    } t_state;

    t_state          r_state, n_state;
    pr80_pkg::t_mode r_mode, n_mode;
    logic            r_both, n_both;
    logic [4:0]      r_n, n_n;
    logic [63:0]     r_s, n_s;
    pr80_pkg::t_key  r_key, n_key;
    logic [4:0]      r_kidx, n_kidx;
    pr80_pkg::t_key  r_kc, n_kc;
    logic            r_kc_ok, n_kc_ok;
    logic            r_ov, n_ov;
    pr80_pkg::t_res  r_o, n_o;

    pr80_pkg::t_key  cfg_key;
    pr80_pkg::t_key  key_step_fwd;
    pr80_pkg::t_key  key_step_inv;
    logic [63:0]     e_added, e_sub;
    logic [63:0]     d_perm, d_sub;
    logic            out_free;
    logic            done;
    logic            fin;

    assign cfg_key.hi   = i_key_upper;
    assign cfg_key.lo   = i_key_lower;
    assign key_step_fwd = pr80_pkg::key_fwd(r_key, r_kidx + 5'd1);
    assign key_step_inv = pr80_pkg::key_inv(r_key, r_kidx);

    // Round datapath for both directions.
    assign e_added = r_s ^ r_key.hi;
    assign e_sub   = pr80_pkg::sub_fwd(e_added);
    assign d_perm  = pr80_pkg::perm_inv(r_s ^ r_key.hi);
    assign d_sub   = pr80_pkg::sub_inv(d_perm);

    assign out_free = !r_ov || o_out.ready;
    assign done     = (r_mode == pr80_pkg::MODE_DEC) ? (r_kidx == '0) : (r_kidx == r_n);
    assign fin      = (r_state == ST_RUN) && out_free && done;

    // Sequencer: load a request, warm up the key for decryption unless cached, run rounds.
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_both  = r_both;
        n_n     = r_n;
        n_s     = r_s;
        n_key   = r_key;
        n_kidx  = r_kidx;
        n_kc    = r_kc;
        n_kc_ok = r_kc_ok;
        n_ov    = r_ov && !o_out.ready;
        n_o     = r_o;
        o_q_pop = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_mode  = i_q_req.mode;
                    n_both  = i_q_req.tap_both;
                    n_n     = i_q_req.rounds;
                    n_s     = i_q_req.text;
                    n_key   = cfg_key;
                    n_kidx  = '0;
                    n_state = ST_RUN;
                    if (i_q_req.mode == pr80_pkg::MODE_DEC) begin
                        if (r_kc_ok) begin
                            // The last round key is still cached.
                            n_key  = r_kc;
                            n_kidx = i_q_req.rounds;
                        end else if (i_q_req.rounds != '0) begin
                            n_state = ST_WARM;
                        end
                    end
                end
            end
            ST_WARM: begin
                // Step the schedule forward up to the last round key.
                n_key  = key_step_fwd;
                n_kidx = r_kidx + 5'd1;
                if (r_kidx + 5'd1 == r_n) begin
                    n_kc    = key_step_fwd;
                    n_kc_ok = 1'b1;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    if (done) begin
                        n_o.round_index = r_n;
                        n_o.tap_first   = '0;
                        n_o.tap_second  = '0;
                        n_o.text_out    = r_s ^ r_key.hi;
                        n_o.last        = 1'b1;
                        n_state         = ST_IDLE;
                    end else if (r_mode == pr80_pkg::MODE_ENC) begin
                        n_o.round_index = r_kidx;
                        n_o.tap_first   = r_both ? e_added : e_sub;
                        n_o.tap_second  = r_both ? e_sub : 64'd0;
                        n_o.text_out    = '0;
                        n_o.last        = 1'b0;
                        n_s             = pr80_pkg::perm_fwd(e_sub);
                        n_key           = key_step_fwd;
                        n_kidx          = r_kidx + 5'd1;
                    end else begin
                        n_o.round_index = r_kidx - 5'd1;
                        n_o.tap_first   = r_both ? d_sub : d_perm;
                        n_o.tap_second  = r_both ? d_perm : 64'd0;
                        n_o.text_out    = '0;
                        n_o.last        = 1'b0;
                        n_s             = d_sub;
                        n_key           = key_step_inv;
                        n_kidx          = r_kidx - 5'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // Any register write makes the cached last round key stale.
        if (i_cfg_wr) begin
            n_kc_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kc_ok <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kc_ok <= n_kc_ok;
            r_ov    <= n_ov;
        end
    end

    // Working state and output register.
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_both <= n_both;
        r_n    <= n_n;
        r_s    <= n_s;
        r_key  <= n_key;
        r_kidx <= n_kidx;
        r_kc   <= n_kc;
        r_o    <= n_o;
    end

    assign o_out.valid       = r_ov;
    assign o_out.round_index = r_o.round_index;
    assign o_out.tap_first   = r_o.tap_first;
    assign o_out.tap_second  = r_o.tap_second;
    assign o_out.text_out    = r_o.text_out;
    assign o_out.last        = r_o.last;

    // Checks on the sequencer.
    `ASSERT_ONEHOT(a_state_onehot, i_clk, i_rst_n, r_state)
    `ASSERT_PROP(a_kidx_range, i_clk, i_rst_n, (r_state != ST_IDLE) |-> (r_kidx <= r_n))
    `ASSERT_PROP(a_warm_dec, i_clk, i_rst_n, (r_state == ST_WARM) |-> (!r_kc_ok && r_mode == pr80_pkg::MODE_DEC))
    `ASSERT_PROP(a_final_idle, i_clk, i_rst_n, fin |=> (r_state == ST_IDLE && r_ov && r_o.last))
    `ASSERT_PROP(a_cfg_flush, i_clk, i_rst_n, i_cfg_wr |=> !r_kc_ok)

endmodule

/* rtl/present80_block_cipher_with_taps.sv */
// Top level of the PRESENT-80 cipher block with per-round taps.
//
//   channel   direction  request carries
//   i_in      in         mode, tap_both, text_in
//   o_out     out        round_index, tap_first, tap_second, text_out, last
//   APB       in/out     round_count, key_upper, key_lower (8-byte stride)
//
// The engine runs one round per cycle while the output is not stalled; n is the
// saturated round count. Encryption goes through load, n rounds, final result.
// Decryption first steps the key schedule forward to the last round key; that
// key is cached, so later blocks skip that walk until the next register write.
// Reset is synchronous; a stalled output holds the engine, while the request
// queue (two entries by default) keeps accepting requests until it is full.
`timescale 1ns / 1ps
module present80_block_cipher_with_taps #(
    parameter int QUEUE_DEPTH = pr80_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pr80_in_if.sink      i_in,
    pr80_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [4:0]     r_round_count;
    logic [63:0]    r_key_upper;
    logic [15:0]    r_key_lower;
    logic           cfg_wr;
    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    pr80_pkg::t_req front_req;
    pr80_pkg::t_req q_req;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_count <= 5'd31;
            r_key_upper   <= '0;
            r_key_lower   <= '0;
        end else if (cfg_wr) begin
            case (paddr)
                pr80_pkg::ADDR_ROUND_COUNT: r_round_count <= pwdata[4:0];
                pr80_pkg::ADDR_KEY_UPPER:   r_key_upper   <= pwdata;
                pr80_pkg::ADDR_KEY_LOWER:   r_key_lower   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (paddr)
            pr80_pkg::ADDR_ROUND_COUNT: prdata = {59'd0, r_round_count};
            pr80_pkg::ADDR_KEY_UPPER:   prdata = r_key_upper;
            pr80_pkg::ADDR_KEY_LOWER:   prdata = {48'd0, r_key_lower};
            default:                    prdata = '0;
        endcase
    end

    pr80_front u_front (
        .i_in          (i_in),
        .i_round_count (r_round_count),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_req         (front_req)
    );

    pr80_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (front_req),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    pr80_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .i_key_upper (r_key_upper),
        .i_key_lower (r_key_lower),
        .i_cfg_wr    (cfg_wr),
        .o_out       (o_out)
    );

endmodule

/* tb/tb_present80_block_cipher_with_taps.sv */
// Self-checking testbench for the PRESENT-80 cipher block with per-round taps.
`timescale 1ns / 1ps
module tb_present80_block_cipher_with_taps;

    localparam int CLK_HALF     = 10;
    localparam int CYCLE_LIMIT  = 600000;
    // Worst case after a register write: key walk, every round, final result.
    localparam int DRAIN_CYCLES = 2 * pr80_pkg::MAX_ROUNDS + 8;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 24;
    localparam int PHASE_COUNT  = 8;

    localparam logic [3:0] NIB_FWD [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] NIB_INV [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    // Ways the result side applies back-pressure.
    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_HEAVY,
        RX_LIGHT
    } t_rx_style;

    // Mirror of the cipher settings plus the list of taps still to arrive.
    class tap_scoreboard;
        logic [4:0]      rounds;
        logic [63:0]     key_hi;
        logic [15:0]     key_lo;
        pr80_pkg::t_res  pending_taps[$];
        int              errors;
        int              blocks;
        int              results;

        function new();
            rounds  = 5'd31;
            key_hi  = '0;
            key_lo  = '0;
            errors  = 0;
            blocks  = 0;
            results = 0;
        endfunction

        // Nibble substitution over the whole state.
        function logic [63:0] sub_nibbles(logic [63:0] s, bit inverse);
            logic [63:0] t;
            int          i;
            t = '0;
            for (i = 0; i < 16; i++) begin
                t[4*i +: 4] = inverse ? NIB_INV[s[4*i +: 4]] : NIB_FWD[s[4*i +: 4]];
            end
            return t;
        endfunction

        // Bit k goes to (mul * k) mod 63, the top bit stays put.
        function logic [63:0] shuffle_bits(logic [63:0] s, int mul);
            logic [63:0] t;
            int          k;
            int          pos;
            t = '0;
            for (k = 0; k < 64; k++) begin
                pos = (k == 63) ? 63 : (mul * k) % 63;
                t[pos] = s[k];
            end
            return t;
        endfunction

        // Works out every tap and the final text of one accepted block.
        function void note_block(pr80_pkg::t_mode m, logic both, logic [63:0] txt);
            logic [63:0]    rk [32];
            logic [79:0]    k;
            logic [63:0]    s;
            logic [63:0]    mid;
            pr80_pkg::t_res r;
            int             n;
            int             i;
            n = int'(rounds);
            k = {key_hi, key_lo};
            // Key schedule: the round key is the top 64 bits before each step.
            for (i = 0; i <= n; i++) begin
                rk[i] = k[79:16];
                k = {k[18:0], k[79:19]};
                k[79:76] = NIB_FWD[k[79:76]];
                k[19:15] = k[19:15] ^ 5'(i + 1);
            end
            s = txt;
            r.text_out = '0;
            r.last = 1'b0;
            if (m == pr80_pkg::MODE_ENC) begin
                for (i = 0; i < n; i++) begin
                    s = s ^ rk[i];
                    mid = s;
                    s = sub_nibbles(s, 1'b0);
                    r.round_index = 5'(i);
                    r.tap_first = both ? mid : s;
                    r.tap_second = both ? s : '0;
                    pending_taps.push_back(r);
                    s = shuffle_bits(s, 16);
                end
                s = s ^ rk[n];
            end else begin
                // Decryption walks the rounds from the last one down.
                for (i = 0; i < n; i++) begin
                    s = s ^ rk[n - i];
                    s = shuffle_bits(s, 4);
                    mid = s;
                    s = sub_nibbles(s, 1'b1);
                    r.round_index = 5'(n - 1 - i);
                    r.tap_first = both ? s : mid;
                    r.tap_second = both ? mid : '0;
                    pending_taps.push_back(r);
                end
                s = s ^ rk[0];
            end
            r.round_index = 5'(n);
            r.tap_first = '0;
            r.tap_second = '0;
            r.text_out = s;
            r.last = 1'b1;
            pending_taps.push_back(r);
            blocks++;
        endfunction

        // Compares one delivered result against the oldest pending one.
        function void check_result(pr80_pkg::t_res got);
            pr80_pkg::t_res want;
            results++;
            if (pending_taps.size() == 0) begin
                $error("result arrived with nothing pending: round_index %0d last %0b",
                       got.round_index, got.last);
                errors++;
                return;
            end
            want = pending_taps.pop_front();
            if (got.round_index !== want.round_index) begin
                $error("round_index: expected %0d, got %0d", want.round_index, got.round_index);
                errors++;
            end
            if (got.tap_first !== want.tap_first) begin
                $error("tap_first: expected %h, got %h", want.tap_first, got.tap_first);
                errors++;
            end
            if (got.tap_second !== want.tap_second) begin
                $error("tap_second: expected %h, got %h", want.tap_second, got.tap_second);
                errors++;
            end
            if (got.text_out !== want.text_out) begin
                $error("text_out: expected %h, got %h", want.text_out, got.text_out);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    pr80_in_if  in_ch ();
    pr80_out_if out_ch ();

    tap_scoreboard board = new();

    int cycles = 0;
    int burst_left = 0;
    int settings_used = 0;
    bit long_hold_req = 1'b0;

    present80_block_cipher_with_taps dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_present80_block_cipher_with_taps: FAIL");
            $finish;
        end
    end

    // Every accepted result goes to the scoreboard.
    always @(posedge i_clk) begin
        pr80_pkg::t_res got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.round_index = out_ch.round_index;
            got.tap_first = out_ch.tap_first;
            got.tap_second = out_ch.tap_second;
            got.text_out = out_ch.text_out;
            got.last = out_ch.last;
            board.check_result(got);
        end
    end

    // Result side: stall styles change in spans; a long hold-off on request.
    initial begin
        t_rx_style style;
        int        span;
        int        hold_left;
        style = RX_OPEN;
        span = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (span == 0) begin
                    style = t_rx_style'($urandom_range(0, 3));
                    span = $urandom_range(10, 80);
                end
                span--;
                case (style)
                    RX_OPEN:  out_ch.ready <= 1'b1;
                    RX_HALF:  out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:  out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offers one block request, with random gaps between bursts.
    task automatic offer_block(pr80_pkg::t_mode m, logic both, logic [63:0] txt);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.mode <= m;
        in_ch.tap_both <= both;
        in_ch.text_in <= txt;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        board.note_block(m, both, txt);
    endtask

    // Random block request.
    task automatic offer_random_block();
        offer_block(pr80_pkg::t_mode'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    {$urandom(), $urandom()});
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(pr80_pkg::t_reg_addr a, logic [63:0] d);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (a)
            pr80_pkg::ADDR_ROUND_COUNT: board.rounds = d[4:0];
            pr80_pkg::ADDR_KEY_UPPER:   board.key_hi = d;
            default:                    board.key_lo = d[15:0];
        endcase
    endtask

    // Register read, compared against the mirrored value.
    task automatic read_reg(pr80_pkg::t_reg_addr a, logic [63:0] want);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= a;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== want) begin
            $error("%s: expected %h, got %h", a.name(), want, prdata);
            board.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_all_regs();
        read_reg(pr80_pkg::ADDR_ROUND_COUNT, 64'(board.rounds));
        read_reg(pr80_pkg::ADDR_KEY_UPPER, board.key_hi);
        read_reg(pr80_pkg::ADDR_KEY_LOWER, 64'(board.key_lo));
    endtask

    // Drains the block, then loads a new round count and key.
    task automatic apply_setting(logic [4:0] n, logic [63:0] hi, logic [15:0] lo);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (board.pending_taps.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        write_reg(pr80_pkg::ADDR_KEY_UPPER, hi);
        write_reg(pr80_pkg::ADDR_KEY_LOWER, 64'(lo));
        write_reg(pr80_pkg::ADDR_ROUND_COUNT, 64'(n));
        read_all_regs();
        settings_used++;
    endtask

    // Main sequence: reset, directed requests, then random phases.
    initial begin
        logic [4:0]  n;
        logic [63:0] hi;
        logic [15:0] lo;
        int          p;
        int          i;
        i_rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= pr80_pkg::MODE_ENC;
        in_ch.tap_both <= 1'b0;
        in_ch.text_in <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values, then the standard setting with an all-zero key.
        read_all_regs();
        offer_block(pr80_pkg::MODE_ENC, 1'b0, 64'h0);
        offer_block(pr80_pkg::MODE_ENC, 1'b1, 64'h0);
        offer_block(pr80_pkg::MODE_ENC, 1'b0, '1);
        offer_block(pr80_pkg::MODE_DEC, 1'b1, '1);
        offer_block(pr80_pkg::MODE_DEC, 1'b0, 64'h0);
        offer_block(pr80_pkg::MODE_ENC, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        offer_block(pr80_pkg::MODE_DEC, 1'b1, 64'h5555_5555_5555_5555);

        // Full rounds with an all-ones key.
        apply_setting(5'd31, '1, 16'hFFFF);
        offer_block(pr80_pkg::MODE_ENC, 1'b1, 64'h0123_4567_89AB_CDEF);
        offer_block(pr80_pkg::MODE_DEC, 1'b0, 64'hFEDC_BA98_7654_3210);
        offer_block(pr80_pkg::MODE_DEC, 1'b1, 64'h0);
        offer_block(pr80_pkg::MODE_ENC, 1'b0, '1);

        // Zero round count: only the final key add.
        apply_setting(5'd0, {$urandom(), $urandom()}, 16'($urandom()));
        offer_block(pr80_pkg::MODE_ENC, 1'b0, {$urandom(), $urandom()});
        offer_block(pr80_pkg::MODE_DEC, 1'b1, {$urandom(), $urandom()});
        offer_block(pr80_pkg::MODE_ENC, 1'b1, '1);

        // A single round.
        apply_setting(5'd1, 64'h0, 16'hFFFF);
        offer_block(pr80_pkg::MODE_ENC, 1'b1, {$urandom(), $urandom()});
        offer_block(pr80_pkg::MODE_DEC, 1'b1, {$urandom(), $urandom()});
        offer_block(pr80_pkg::MODE_DEC, 1'b0, {$urandom(), $urandom()});

        // Random phases over several round counts and keys.
        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0, 2, 7: n = 5'd31;
                1:       n = 5'd1;
                3:       n = 5'd0;
                4:       n = 5'($urandom_range(2, 30));
                5:       n = 5'($urandom_range(1, 6));
                default: n = 5'($urandom_range(0, 31));
            endcase
            case (p % 3)
                0:       begin hi = '0; lo = '0; end
                1:       begin hi = '1; lo = '1; end
                default: begin hi = {$urandom(), $urandom()}; lo = 16'($urandom()); end
            endcase
            apply_setting(n, hi, lo);
            // One phase starts under a long receiver hold-off so the queue fills.
            if (p == 2) begin
                long_hold_req = 1'b1;
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                offer_random_block();
            end
        end

        // Let the last results drain.
        in_ch.valid <= 1'b0;
        while (board.pending_taps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d blocks and %0d results over %0d register settings.",
                 board.blocks, board.results, settings_used + 1);
        $display("Both directions, single and double taps, round counts 0, 1 and 31.");
        if (board.errors == 0) begin
            $display("tb_present80_block_cipher_with_taps: PASS");
        end else begin
            $display("tb_present80_block_cipher_with_taps: FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pr80_pkg.sv
rtl/pr80_in_if.sv
rtl/pr80_out_if.sv
rtl/pr80_front.sv
rtl/pr80_queue.sv
rtl/pr80_engine.sv
rtl/present80_block_cipher_with_taps.sv
tb/tb_present80_block_cipher_with_taps.sv
